### design/ffra_pkg.sv
// Shared types and codes for the first-fit region allocator.
package ffra_pkg;

  localparam int FIELD_W = 16;
  localparam int APB_AW  = 3;

  localparam logic REG_POOL_BASE = 1'b0;
  localparam logic REG_POOL_SIZE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2
  } status_code_t;

  typedef struct packed {
    logic               func;
    logic [FIELD_W-1:0] block_size;
    logic [FIELD_W-1:0] release_base;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] alloc_base;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_INIT,
    OP_LOAD,
    OP_RES_NOFIT,
    OP_RES_FULL,
    OP_GRANT,
    OP_INC,
    OP_SAVE_PREV,
    OP_SAVE_NEXT,
    OP_RM_MOVE,
    OP_DEC_CNT,
    OP_MERGE_BOTH,
    OP_MERGE_PREV,
    OP_MERGE_NEXT,
    OP_INS_BEGIN,
    OP_INS_MOVE,
    OP_INS_PUT,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic is_release;
    logic zero_size;
    logic cnt_zero;
    logic fit;
    logic grant_empty;
    logic last;
    logic at_end;
    logic below;
    logic at_idx;
    logic full;
    logic merge_prev;
    logic merge_next;
    logic out_busy;
  } dp_status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_START,
    S_A_CHK,
    S_A_WAIT,
    S_RM_CHK,
    S_RM_WR,
    S_REL_SCAN,
    S_REL_WAIT,
    S_REL_DEC,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_FIN
  } ctrl_state_t;

endpackage

### design/ffra_ctrl.sv
// Sequencer that steps the region table datapath through each request.
module ffra_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ffra_pkg::dp_status_t st,
  output ffra_pkg::dp_op_t    op
);
  import ffra_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_INIT: state_next = S_IDLE;
      S_IDLE: if (in_valid) state_next = S_START;
      S_START: begin
        if (!st.is_release) begin
          if (st.zero_size || st.cnt_zero) state_next = S_FIN;
          else state_next = S_A_CHK;
        end else begin
          if (st.zero_size) state_next = S_FIN;
          else if (st.cnt_zero) state_next = S_REL_DEC;
          else state_next = S_REL_SCAN;
        end
      end
      S_A_CHK: begin
        if (st.fit) state_next = st.grant_empty ? S_RM_CHK : S_FIN;
        else if (st.last) state_next = S_FIN;
        else state_next = S_A_WAIT;
      end
      S_A_WAIT: state_next = S_A_CHK;
      S_RM_CHK: state_next = st.at_end ? S_FIN : S_RM_WR;
      S_RM_WR: state_next = S_RM_CHK;
      S_REL_SCAN: begin
        if (st.below && !st.last) state_next = S_REL_WAIT;
        else state_next = S_REL_DEC;
      end
      S_REL_WAIT: state_next = S_REL_SCAN;
      S_REL_DEC: begin
        if (st.merge_prev && st.merge_next) state_next = S_RM_CHK;
        else if (st.merge_prev || st.merge_next || st.full) state_next = S_FIN;
        else if (st.at_end) state_next = S_FIN;
        else state_next = S_INS_RD;
      end
      S_INS_RD: state_next = S_INS_WR;
      S_INS_WR: state_next = st.at_idx ? S_INS_PUT : S_INS_RD;
      S_INS_PUT: state_next = S_FIN;
      S_FIN: if (!st.out_busy) state_next = S_IDLE;
      default: state_next = S_INIT;
    endcase
  end

  always_comb begin
    op       = OP_NOP;
    in_stall = (state != S_IDLE);
    case (state)
      S_INIT: op = OP_INIT;
      S_IDLE: if (in_valid) op = OP_LOAD;
      S_START: begin
        if (!st.is_release && (st.zero_size || st.cnt_zero)) op = OP_RES_NOFIT;
      end
      S_A_CHK: begin
        if (st.fit) op = OP_GRANT;
        else if (st.last) op = OP_RES_NOFIT;
        else op = OP_INC;
      end
      S_RM_CHK: if (st.at_end) op = OP_DEC_CNT;
      S_RM_WR: op = OP_RM_MOVE;
      S_REL_SCAN: op = st.below ? OP_SAVE_PREV : OP_SAVE_NEXT;
      S_REL_DEC: begin
        if (st.merge_prev && st.merge_next) op = OP_MERGE_BOTH;
        else if (st.merge_prev) op = OP_MERGE_PREV;
        else if (st.merge_next) op = OP_MERGE_NEXT;
        else if (st.full) op = OP_RES_FULL;
        else if (st.at_end) op = OP_INS_PUT;
        else op = OP_INS_BEGIN;
      end
      S_INS_WR: op = OP_INS_MOVE;
      S_INS_PUT: op = OP_INS_PUT;
      S_FIN: if (!st.out_busy) op = OP_EMIT;
      default: op = OP_NOP;
    endcase
  end

endmodule

### design/ffra_dp.sv
// Region table memory, scan pointer, merge arithmetic and result register.
module ffra_dp #(
  parameter int MAX_REGIONS = 16,
  parameter int ADDR_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  ffra_pkg::dp_op_t    op,
  output ffra_pkg::dp_status_t st,
  input  ffra_pkg::in_item_t  in_data,
  input  logic                cfg_load,
  input  logic [ADDR_BITS-1:0] pool_base,
  input  logic [ADDR_BITS-1:0] pool_len,
  output logic                out_valid,
  input  logic                out_stall,
  output ffra_pkg::out_item_t out_data
);
  import ffra_pkg::*;

  localparam int AW = ADDR_BITS;
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int IW = $clog2(MAX_REGIONS);

  logic [AW-1:0] mem_start [MAX_REGIONS];
  logic [AW-1:0] mem_len   [MAX_REGIONS];

  logic [AW-1:0] rd_start, rd_len;
  logic [AW-1:0] req_size, req_base;
  logic          req_rel;
  logic [AW-1:0] prev_start, prev_len, next_start, next_len;
  logic          have_next;
  logic [CW-1:0] ptr, idx, count;
  logic [1:0]    res_status;
  logic [AW-1:0] res_base;

  logic          wr_en;
  logic [CW-1:0] wr_addr;
  logic [AW-1:0] wr_start, wr_len;
  logic [IW-1:0] rd_idx;

  logic [AW:0]   prev_end, new_end, prev_sum, next_sum;
  logic [AW+1:0] both_sum;
  logic          have_prev, mp, mn0;

  assign rd_idx = (ptr < CW'(MAX_REGIONS)) ? ptr[IW-1:0] : '0;

  always_ff @(posedge clk) begin
    rd_start <= mem_start[rd_idx];
    rd_len   <= mem_len[rd_idx];
    if (wr_en) begin
      mem_start[wr_addr[IW-1:0]] <= wr_start;
      mem_len[wr_addr[IW-1:0]]   <= wr_len;
    end
  end

  // merge checks use the unwrapped sums
  assign have_prev = (ptr != '0);
  assign prev_end  = {1'b0, prev_start} + {1'b0, prev_len};
  assign new_end   = {1'b0, req_base} + {1'b0, req_size};
  assign prev_sum  = {1'b0, prev_len} + {1'b0, req_size};
  assign next_sum  = {1'b0, next_len} + {1'b0, req_size};
  assign both_sum  = {1'b0, prev_sum} + {2'b00, next_len};
  assign mp  = have_prev && (prev_end == {1'b0, req_base}) && !prev_sum[AW];
  assign mn0 = have_next && (new_end == {1'b0, next_start}) && !next_sum[AW];

  always_comb begin
    wr_en    = cfg_load;
    wr_addr  = '0;
    wr_start = pool_base;
    wr_len   = pool_len;
    if (!cfg_load) begin
      case (op)
        OP_INIT: wr_en = 1'b1;
        OP_GRANT: begin
          wr_en    = (rd_len != req_size);
          wr_addr  = ptr;
          wr_start = rd_start + req_size;
          wr_len   = rd_len - req_size;
        end
        OP_RM_MOVE: begin
          wr_en    = 1'b1;
          wr_addr  = ptr - CW'(1);
          wr_start = rd_start;
          wr_len   = rd_len;
        end
        OP_MERGE_BOTH: begin
          wr_en    = 1'b1;
          wr_addr  = ptr - CW'(1);
          wr_start = prev_start;
          wr_len   = both_sum[AW-1:0];
        end
        OP_MERGE_PREV: begin
          wr_en    = 1'b1;
          wr_addr  = ptr - CW'(1);
          wr_start = prev_start;
          wr_len   = prev_sum[AW-1:0];
        end
        OP_MERGE_NEXT: begin
          wr_en    = 1'b1;
          wr_addr  = ptr;
          wr_start = req_base;
          wr_len   = next_sum[AW-1:0];
        end
        OP_INS_MOVE: begin
          wr_en    = 1'b1;
          wr_addr  = ptr + CW'(1);
          wr_start = rd_start;
          wr_len   = rd_len;
        end
        OP_INS_PUT: begin
          wr_en    = 1'b1;
          wr_addr  = ptr;
          wr_start = req_base;
          wr_len   = req_size;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_load) begin
        count <= (pool_len != '0) ? CW'(1) : '0;
      end else begin
        case (op)
          OP_INIT:    count <= (pool_len != '0) ? CW'(1) : '0;
          OP_DEC_CNT: count <= count - CW'(1);
          OP_INS_PUT: count <= count + CW'(1);
          OP_EMIT:    out_valid <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        req_rel    <= in_data.func;
        req_size   <= AW'(in_data.block_size);
        req_base   <= AW'(in_data.release_base);
        ptr        <= '0;
        have_next  <= 1'b0;
        res_status <= ST_DONE;
        res_base   <= '0;
      end
      OP_RES_NOFIT: res_status <= ST_NOFIT;
      OP_RES_FULL:  res_status <= ST_FULL;
      OP_GRANT: begin
        res_base <= rd_start;
        if (rd_len == req_size) ptr <= ptr + CW'(1);
      end
      OP_INC:        ptr <= ptr + CW'(1);
      OP_SAVE_PREV: begin
        prev_start <= rd_start;
        prev_len   <= rd_len;
        ptr        <= ptr + CW'(1);
      end
      OP_SAVE_NEXT: begin
        next_start <= rd_start;
        next_len   <= rd_len;
        have_next  <= 1'b1;
      end
      OP_RM_MOVE:    ptr <= ptr + CW'(1);
      OP_MERGE_BOTH: ptr <= ptr + CW'(1);
      OP_INS_BEGIN: begin
        idx <= ptr;
        ptr <= count - CW'(1);
      end
      OP_INS_MOVE: if (ptr != idx) ptr <= ptr - CW'(1);
      OP_EMIT: begin
        out_data.status     <= res_status;
        out_data.alloc_base <= FIELD_W'(res_base);
      end
      default: ;
    endcase
  end

  always_comb begin
    st.is_release  = req_rel;
    st.zero_size   = (req_size == '0);
    st.cnt_zero    = (count == '0);
    st.fit         = (rd_len >= req_size);
    st.grant_empty = (rd_len == req_size);
    st.last        = ({1'b0, ptr} + (CW+1)'(1)) == {1'b0, count};
    st.at_end      = (ptr == count);
    st.below       = (rd_start < req_base);
    st.at_idx      = (ptr == idx);
    st.full        = (count == CW'(MAX_REGIONS));
    st.merge_prev  = mp;
    st.merge_next  = mn0 && !(mp && (both_sum[AW+1:AW] != 2'b00));
    st.out_busy    = out_valid && out_stall;
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_REGIONS))
    else $error("region count above table depth");
  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    (op == OP_INS_PUT) |-> (count < CW'(MAX_REGIONS)))
    else $error("insert into a full table");
  a_grant_fits: assert property (@(posedge clk) disable iff (rst)
    (op == OP_GRANT) |-> (rd_len >= req_size))
    else $error("grant from a region that is too small");
  a_write_in_table: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (wr_addr < CW'(MAX_REGIONS)))
    else $error("table write beyond depth");
`endif

endmodule

### design/first_fit_region_allocator_unit.sv
// Top level: configuration registers, sequencer and region table datapath.
// Keeps up to MAX_REGIONS free regions sorted by start address in a one-read,
// one-write table memory. Allocate takes the first region large enough and
// trims it from the front; release inserts the region in order and merges it
// with touching neighbors. One item at a time: allocate and release scan the
// table entry by entry, and removing or inserting an entry moves the entries
// one by one, since every step goes through the single read port of the table.
// One result per item, held in an output register so the next item may enter
// while it waits. After reset the table loads with the pool in the S_INIT state;
// a write to either register reloads it with the pool.
module first_fit_region_allocator_unit #(
  parameter int MAX_REGIONS = 16,
  parameter int ADDR_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ffra_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ffra_pkg::out_item_t                 out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ffra_pkg::APB_AW-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import ffra_pkg::*;

  logic [FIELD_W-1:0] pool_base, pool_size;
  logic               cfg_wr;
  dp_op_t             op;
  dp_status_t         st;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
      pool_size <= FIELD_W'(1024);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_POOL_BASE: pool_base <= pwdata[FIELD_W-1:0];
        REG_POOL_SIZE: pool_size <= pwdata[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  assign prdata = {16'h0000, (paddr[2] == REG_POOL_SIZE) ? pool_size : pool_base};

  ffra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .op       (op)
  );

  ffra_dp #(
    .MAX_REGIONS (MAX_REGIONS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .st        (st),
    .in_data   (in_data),
    .cfg_load  (cfg_wr),
    .pool_base (ADDR_BITS'(cfg_wr && paddr[2] == REG_POOL_BASE ?
                           pwdata[FIELD_W-1:0] : pool_base)),
    .pool_len  (ADDR_BITS'(cfg_wr && paddr[2] == REG_POOL_SIZE ?
                           pwdata[FIELD_W-1:0] : pool_size)),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### tb/sv/tb.sv
// Testbench for the first-fit region allocator: directed and random beats, scoreboard check.
`timescale 1ns / 100ps

module tb;
  import ffra_pkg::*;

  // Predicts every reply from a private copy of the region table and checks replies in order.
  class region_book;
    int unsigned  rstart[16];
    int unsigned  rlen[16];
    int unsigned  rcount;
    int unsigned  cfg_base;
    int unsigned  cfg_size;
    out_item_t    awaited[$];
    int unsigned  live_base[$];
    int unsigned  live_size[$];
    int           errors;

    function new();
      cfg_base = 0;
      cfg_size = 1024;
      errors   = 0;
      reload();
    endfunction

    function void reload();
      rstart[0] = cfg_base;
      rlen[0]   = cfg_size;
      rcount    = (cfg_size != 0) ? 1 : 0;
      live_base.delete();
      live_size.delete();
    endfunction

    function void set_reg(int idx, int unsigned value);
      if (idx == REG_POOL_BASE) cfg_base = value & 16'hFFFF;
      else cfg_size = value & 16'hFFFF;
      reload();
    endfunction

    function void drop_entry(int unsigned idx);
      for (int unsigned i = idx; i + 1 < rcount; i++) begin
        rstart[i] = rstart[i+1];
        rlen[i]   = rlen[i+1];
      end
      rcount--;
    endfunction

    function out_item_t grant(int unsigned size);
      out_item_t r;
      r.status     = ST_NOFIT;
      r.alloc_base = '0;
      if (size == 0) return r;
      for (int unsigned i = 0; i < rcount; i++) begin
        if (rlen[i] >= size) begin
          r.status     = ST_DONE;
          r.alloc_base = rstart[i][15:0];
          rstart[i]    = (rstart[i] + size) & 16'hFFFF;
          rlen[i]      = rlen[i] - size;
          if (rlen[i] == 0) drop_entry(i);
          live_base.push_back(r.alloc_base);
          live_size.push_back(size);
          return r;
        end
      end
      return r;
    endfunction

    function logic [1:0] give_back(int unsigned base, int unsigned size);
      int unsigned pos;
      bit          mp;
      bit          mn;
      pos = 0;
      mp  = 0;
      mn  = 0;
      if (size == 0) return ST_DONE;
      while (pos < rcount && rstart[pos] < base) pos++;
      if (pos > 0 && rstart[pos-1] + rlen[pos-1] == base && rlen[pos-1] + size <= 16'hFFFF)
        mp = 1;
      if (pos < rcount && base + size == rstart[pos] && rlen[pos] + size <= 16'hFFFF)
        mn = 1;
      if (mp && mn && rlen[pos-1] + size + rlen[pos] > 16'hFFFF) mn = 0;
      if (mp && mn) begin
        rlen[pos-1] += size + rlen[pos];
        drop_entry(pos);
      end else if (mp) begin
        rlen[pos-1] += size;
      end else if (mn) begin
        rstart[pos] = base;
        rlen[pos]  += size;
      end else begin
        if (rcount >= 16) return ST_FULL;
        for (int unsigned i = rcount; i > pos; i--) begin
          rstart[i] = rstart[i-1];
          rlen[i]   = rlen[i-1];
        end
        rstart[pos] = base;
        rlen[pos]   = size;
        rcount++;
      end
      return ST_DONE;
    endfunction

    function void note_request(in_item_t it);
      out_item_t r;
      if (it.func == 1'b0) begin
        r = grant(it.block_size);
      end else begin
        r.status     = give_back(it.release_base, it.block_size);
        r.alloc_base = '0;
      end
      awaited.push_back(r);
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected reply status=%0d base=%h", $time, got.status, got.alloc_base);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.alloc_base !== want.alloc_base) begin
        $display("%0t: alloc_base expected %h actual %h", $time, want.alloc_base,
                 got.alloc_base);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  region_book  book = new();
  bit          jitter = 1'b1;
  int          hold_left = 0;
  longint      cycles = 0;

  first_fit_region_allocator_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: long hold when asked, random stall otherwise.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= jitter && ($urandom_range(99) < 32);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) book.check_reply(out_data);
  end

  task automatic send(input in_item_t it);
    if (jitter && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    book.note_request(it);
  endtask

  task automatic send_op(input logic f, input int unsigned size, input int unsigned base);
    in_item_t it;
    it.func         = f;
    it.block_size   = size[15:0];
    it.release_base = base[15:0];
    send(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (book.awaited.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic reg_write(input int idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    book.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly allocate and return real grants; the rest is arbitrary releases.
  task automatic random_beat();
    int r;
    int k;
    int unsigned b;
    int unsigned s;
    r = $urandom_range(99);
    if (r < 50) begin
      k = $urandom_range(99);
      if (k < 80) s = $urandom_range(1, 48);
      else if (k < 95) s = $urandom_range(1, 512);
      else s = $urandom_range(0, 65535);
      send_op(1'b0, s, $urandom_range(0, 65535));
    end else if (r < 85 && book.live_base.size() != 0) begin
      k = $urandom_range(0, book.live_base.size() - 1);
      b = book.live_base[k];
      s = book.live_size[k];
      book.live_base.delete(k);
      book.live_size.delete(k);
      send_op(1'b1, s, b);
    end else begin
      s = ($urandom_range(9) == 0) ? 0 : $urandom_range(0, 65535) >> $urandom_range(0, 12);
      send_op(1'b1, s, $urandom_range(0, 65535));
    end
  endtask

  initial begin
    int unsigned pool_b[6];
    int unsigned pool_s[6];
    pool_b = '{16'h0000, 16'h0000, 16'hFFF0, 16'h1234, 16'hFFFF, 16'h0100};
    pool_s = '{16'h0400, 16'hFFFF, 16'h0400, 16'h0000, 16'h0001, 16'h0300};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero size, oversize, exact fit, merges, overflowed merge, top of space.
    send_op(1'b0, 0, 16'hFFFF);
    send_op(1'b0, 16'hFFFF, 0);
    send_op(1'b0, 1, 0);
    send_op(1'b0, 1023, 0);
    send_op(1'b0, 1, 0);
    send_op(1'b1, 0, 0);
    send_op(1'b1, 1023, 1);
    send_op(1'b1, 1, 0);
    send_op(1'b0, 100, 0);
    send_op(1'b0, 100, 0);
    send_op(1'b1, 100, 0);
    send_op(1'b1, 100, 100);
    send_op(1'b1, 1, 16'hFFFF);
    send_op(1'b1, 16'hFFFF, 1024);
    send_op(1'b1, 16'hFBFF, 1024);
    send_op(1'b1, 16, 16'hFFF0);
    send_op(1'b0, 16'hFFFF, 0);
    send_op(1'b1, 5, 5000);
    send_op(1'b1, 5, 5000);
    book.live_base.delete();
    book.live_size.delete();
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        reg_write(REG_POOL_BASE, pool_b[ph]);
        reg_write(REG_POOL_SIZE, pool_s[ph]);
      end
      for (int n = 0; n < 88; n++) begin
        if (ph == 1) jitter = (n < 20 || n > 70);
        if (ph == 2 && n == 30) hold_left = 400;
        if (ph == 3 && n == 40) begin
          in_valid <= 1'b0;
          while (book.awaited.size() != 0) @(posedge clk);
        end
        random_beat();
      end
      jitter = 1'b1;
      drain();
    end

    if (book.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
